// File: rtl/tmvg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tmvg_pkg: shared types, constants and trig ROM for the torus vertex generator
// Holds the grid size, the corner order of a cell, the stage bundles and a
// quarter-wave sine/cosine ROM built from a fixed-point Taylor series.
// ----------------------------------------------------------------------------
package tmvg_pkg;

	// grid size, a power of two
	localparam int SEGMENTS  = 64;
	localparam int SEG_W     = $clog2(SEGMENTS);
	localparam int CRN_W     = SEG_W + 1;          // corner index reaches SEGMENTS
	localparam int QUARTER   = SEGMENTS / 4;
	localparam int IDX_W     = $clog2(QUARTER);
	localparam int TEX_SHIFT = 15 - SEG_W;

	// field widths
	localparam int POS_W  = 24;
	localparam int NRM_W  = 16;
	localparam int TEX_W  = 16;
	localparam int RAD_W  = 16;
	localparam int TRIG_W = 15;                    // unsigned magnitude 0..16384

	localparam logic [RAD_W-1:0] RADIUS_RESET = 16'd512;

	// vertex counter
	localparam logic [2:0] LAST_VERTEX = 3'd5;

	// angle pi/2 in Q2.30
	localparam logic [63:0] PIH_Q30 = 64'd1686629713;

	// series divisors (n+1)(n+2) per term
	localparam logic [63:0] SIN_DIV [1:6] = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156};
	localparam logic [63:0] COS_DIV [1:6] = '{64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132};

	// one corner of the cell as it travels down the pipe
	typedef struct packed {
		logic [CRN_W-1:0] a;
		logic [CRN_W-1:0] b;
		logic             last;
	} corner_t;

	// corner plus looked-up trig values
	typedef struct packed {
		corner_t                   crn;
		logic signed [NRM_W-1:0]   sa;
		logic signed [NRM_W-1:0]   ca;
		logic signed [NRM_W-1:0]   sb;
		logic signed [NRM_W-1:0]   cb;
	} trig_t;

	typedef logic [QUARTER-1:0][2*TRIG_W-1:0] rom_t;

	// corner offsets in emission order: (0,0) (0,1) (1,0) (0,1) (1,1) (1,0)
	function automatic logic [1:0] corner_offs(input logic [2:0] cnt);
		logic [1:0] d;    // {major step, minor step}
		case (cnt)
			3'd0:    d = 2'b00;
			3'd1:    d = 2'b01;
			3'd2:    d = 2'b10;
			3'd3:    d = 2'b01;
			3'd4:    d = 2'b11;
			3'd5:    d = 2'b10;
			default: d = 2'b00;
		endcase
		return d;
	endfunction

	// Taylor series in Q30, rounded to Q1.14 magnitude
	function automatic logic [TRIG_W-1:0] series(input logic [63:0] x, input logic sine);
		logic [63:0] x2;
		logic [63:0] term;
		longint      sum;
		x2   = (x * x) >> 30;
		term = sine ? x : (64'd1 << 30);
		sum  = longint'(term);
		for (int t = 1; t < 7; t++) begin
			if (sine) begin
				term = ((term * x2) >> 30) / SIN_DIV[t];
			end else begin
				term = ((term * x2) >> 30) / COS_DIV[t];
			end
			if (t % 2 == 1) begin
				sum = sum - longint'(term);
			end else begin
				sum = sum + longint'(term);
			end
		end
		if (sum < 0) begin
			sum = 0;
		end
		sum = (sum + 32768) >>> 16;
		if (sum > 16384) begin
			sum = 16384;
		end
		return TRIG_W'(sum);
	endfunction

	// quarter-wave ROM: entry holds {sin, cos} of the first quadrant step
	function automatic rom_t build_rom();
		rom_t        rom;
		logic [63:0] x;
		for (int k = 0; k < QUARTER; k++) begin
			x = (PIH_Q30 * 64'(4 * k)) / SEGMENTS;
			rom[k] = {series(x, 1'b1), series(x, 1'b0)};
		end
		return rom;
	endfunction

	localparam rom_t TRIG_ROM = build_rom();

endpackage
`default_nettype wire

// File: rtl/torus_mesh_vertex_generator_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// torus_mesh_vertex_generator_top: torus tessellation vertex generator
// Usage:
//   Input channel (in_valid / in_stall) takes one word per grid cell:
//   cell_major, cell_minor. Output channel (out_valid / out_stall) gives
//   six words per cell, the two triangles' corners in order; last_vertex
//   marks the sixth. Each word holds position (Q9.14), normal (Q1.14) and
//   texture coordinates (Q1.15).
//   Throughput: one vertex per cycle while out_stall does not hold the pipe;
//   the cell sequencer, which emits one corner per cycle, sets this rate.
//   Stages: corner, trig ROM, multiply, round/output.
//   The next cell is taken in the cycle the last corner leaves the sequencer.
//   major_radius (Q8.8) is written through cfg_wr_en / cfg_wr_data; the user
//   must write it only while the block is idle, which the block does not enforce.
//   Reset (arst_n low) empties the pipe and sets major_radius to 2.0.
//   out_stall, while out_valid is high, freezes the whole pipe in place; nothing is dropped or repeated.
//   in_stall stays high while a cell is walked, except in its last-corner cycle when the pipe moves.
// ----------------------------------------------------------------------------
module torus_mesh_vertex_generator_top
	import tmvg_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_wr_en,
	input  wire logic [RAD_W-1:0] cfg_wr_data,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire logic [SEG_W-1:0] cell_major,
	input  wire logic [SEG_W-1:0] cell_minor,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output logic signed [POS_W-1:0] pos_x,
	output logic signed [POS_W-1:0] pos_y,
	output logic signed [POS_W-1:0] pos_z,
	output logic signed [NRM_W-1:0] nrm_x,
	output logic signed [NRM_W-1:0] nrm_y,
	output logic signed [NRM_W-1:0] nrm_z,
	output logic [TEX_W-1:0]        tex_u,
	output logic [TEX_W-1:0]        tex_v,
	output logic                    last_vertex
);

	logic [RAD_W-1:0] major_radius_q;
	logic             en;
	logic             vld_s1, vld_s2;
	corner_t          crn_s1;
	trig_t            trg_s2;

	// whole pipe moves unless the output word is held
	assign en = !out_valid || !out_stall;

	// radius register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			major_radius_q <= RADIUS_RESET;
		end else if (cfg_wr_en) begin
			major_radius_q <= cfg_wr_data;
		end
	end

	tmvg_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.cell_major (cell_major),
		.cell_minor (cell_minor),
		.vld_s1     (vld_s1),
		.crn_s1     (crn_s1)
	);

	tmvg_trig u_trig (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.vld_s1 (vld_s1),
		.crn_s1 (crn_s1),
		.vld_s2 (vld_s2),
		.trg_s2 (trg_s2)
	);

	tmvg_math u_math (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.radius   (major_radius_q),
		.vld_s2   (vld_s2),
		.trg_s2   (trg_s2),
		.vld_s4   (out_valid),
		.pos_x_s4 (pos_x),
		.pos_y_s4 (pos_y),
		.pos_z_s4 (pos_z),
		.nrm_x_s4 (nrm_x),
		.nrm_y_s4 (nrm_y),
		.nrm_z_s4 (nrm_z),
		.tex_u_s4 (tex_u),
		.tex_v_s4 (tex_v),
		.last_s4  (last_vertex)
	);

endmodule
`default_nettype wire

// File: rtl/tmvg_seq.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tmvg_seq: cell sequencer
// Latches one cell and walks its six corners, one per enabled cycle, into
// the first pipeline stage. Takes the next cell on the last corner.
// ----------------------------------------------------------------------------
module tmvg_seq
	import tmvg_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             en,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire logic [SEG_W-1:0] cell_major,
	input  wire logic [SEG_W-1:0] cell_minor,
	output logic                  vld_s1,
	output corner_t               crn_s1
);

	logic             busy_q;
	logic [2:0]       cnt_q;
	logic [SEG_W-1:0] maj_q;
	logic [SEG_W-1:0] min_q;
	logic             accept;
	logic [1:0]       offs;
	corner_t          crn_d;

	// free when idle or when the last corner leaves this cycle
	assign in_stall = busy_q && !(en && (cnt_q == LAST_VERTEX));
	assign accept   = in_valid && !in_stall;

	// current corner
	always_comb begin
		offs       = corner_offs(cnt_q);
		crn_d.a    = {1'b0, maj_q} + CRN_W'(offs[1]);
		crn_d.b    = {1'b0, min_q} + CRN_W'(offs[0]);
		crn_d.last = (cnt_q == LAST_VERTEX);
	end

	// control; a new cell restarts the corner count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= 3'd0;
			vld_s1 <= 1'b0;
		end else begin
			if (en) begin
				vld_s1 <= busy_q;
			end
			if (accept) begin
				busy_q <= 1'b1;
				cnt_q  <= 3'd0;
			end else if (busy_q && en) begin
				if (cnt_q == LAST_VERTEX) begin
					busy_q <= 1'b0;
					cnt_q  <= 3'd0;
				end else begin
					cnt_q <= cnt_q + 3'd1;
				end
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (accept) begin
			maj_q <= cell_major;
			min_q <= cell_minor;
		end
		if (en) begin
			crn_s1 <= crn_d;
		end
	end

endmodule
`default_nettype wire

// File: rtl/tmvg_trig.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tmvg_trig: trig lookup stage
// Reads sine and cosine of both corner angles from the quarter-wave ROM and
// maps them by quadrant into stage 2.
// ----------------------------------------------------------------------------
module tmvg_trig
	import tmvg_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    en,
	input  wire logic    vld_s1,
	input  wire corner_t crn_s1,
	output logic         vld_s2,
	output trig_t        trg_s2
);

	logic signed [NRM_W-1:0] sa_d, ca_d, sb_d, cb_d;

	// quadrant mapping of one angle; the index wraps at SEGMENTS
	function automatic logic [2*NRM_W-1:0] lookup(input logic [CRN_W-1:0] k);
		logic [2*TRIG_W-1:0]     ent;
		logic signed [NRM_W-1:0] sv, cv, s, c;
		logic [1:0]              q;
		ent = TRIG_ROM[k[IDX_W-1:0]];
		q   = k[SEG_W-1:IDX_W];
		sv  = signed'(NRM_W'(ent[2*TRIG_W-1:TRIG_W]));
		cv  = signed'(NRM_W'(ent[TRIG_W-1:0]));
		case (q)
			2'd0:    begin s = sv;  c = cv;  end
			2'd1:    begin s = cv;  c = -sv; end
			2'd2:    begin s = -sv; c = -cv; end
			default: begin s = -cv; c = sv;  end
		endcase
		return {s, c};
	endfunction

	always_comb begin
		{sa_d, ca_d} = lookup(crn_s1.a);
		{sb_d, cb_d} = lookup(crn_s1.b);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			trg_s2.crn <= crn_s1;
			trg_s2.sa  <= sa_d;
			trg_s2.ca  <= ca_d;
			trg_s2.sb  <= sb_d;
			trg_s2.cb  <= cb_d;
		end
	end

endmodule
`default_nettype wire

// File: rtl/tmvg_math.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tmvg_math: multiply and round stages
// Stage 3 forms the ring radius and the four products; stage 4 rounds them
// and is the output register of the block.
// ----------------------------------------------------------------------------
module tmvg_math
	import tmvg_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             en,
	input  wire logic [RAD_W-1:0] radius,
	input  wire logic             vld_s2,
	input  wire trig_t            trg_s2,
	output logic                  vld_s4,
	output logic signed [POS_W-1:0] pos_x_s4,
	output logic signed [POS_W-1:0] pos_y_s4,
	output logic signed [POS_W-1:0] pos_z_s4,
	output logic signed [NRM_W-1:0] nrm_x_s4,
	output logic signed [NRM_W-1:0] nrm_y_s4,
	output logic signed [NRM_W-1:0] nrm_z_s4,
	output logic [TEX_W-1:0]        tex_u_s4,
	output logic [TEX_W-1:0]        tex_v_s4,
	output logic                    last_s4
);

	localparam int PP_W = POS_W + NRM_W;
	localparam int NP_W = 2 * NRM_W;

	logic signed [POS_W-1:0] ring;
	logic signed [PP_W-1:0]  px_d, pz_d;
	logic signed [NP_W-1:0]  nx_d, nz_d;
	logic signed [PP_W-1:0]  px_s3, pz_s3;
	logic signed [NP_W-1:0]  nx_s3, nz_s3;
	logic signed [NRM_W-1:0] sb_s3;
	corner_t                 crn_s3;
	logic                    vld_s3;
	logic signed [PP_W-1:0]  px_r, pz_r;
	logic signed [NP_W-1:0]  nx_r, nz_r;

	// ring radius R + cos B in Q9.14, then products
	always_comb begin
		ring = POS_W'(trg_s2.cb) + signed'({2'b00, radius, 6'b000000});
		px_d = ring * trg_s2.ca;
		pz_d = ring * trg_s2.sa;
		nx_d = trg_s2.cb * trg_s2.ca;
		nz_d = trg_s2.cb * trg_s2.sa;
	end

	// round to nearest, ties up
	always_comb begin
		px_r = (px_s3 + PP_W'(8192)) >>> 14;
		pz_r = (pz_s3 + PP_W'(8192)) >>> 14;
		nx_r = (nx_s3 + NP_W'(8192)) >>> 14;
		nz_r = (nz_s3 + NP_W'(8192)) >>> 14;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			px_s3    <= px_d;
			pz_s3    <= pz_d;
			nx_s3    <= nx_d;
			nz_s3    <= nz_d;
			sb_s3    <= trg_s2.sb;
			crn_s3   <= trg_s2.crn;
			pos_x_s4 <= px_r[POS_W-1:0];
			pos_y_s4 <= POS_W'(sb_s3);
			pos_z_s4 <= pz_r[POS_W-1:0];
			nrm_x_s4 <= nx_r[NRM_W-1:0];
			nrm_y_s4 <= sb_s3;
			nrm_z_s4 <= nz_r[NRM_W-1:0];
			tex_u_s4 <= TEX_W'(crn_s3.a) << TEX_SHIFT;
			tex_v_s4 <= TEX_W'(crn_s3.b) << TEX_SHIFT;
			last_s4  <= crn_s3.last;
		end
	end

endmodule
`default_nettype wire
